// ----- rtl/core/u1lgm_pkg.sv -----
package u1lgm_pkg;

  // lattice geometry: side 4, four coordinates of two bits each
  localparam int COORD_BITS     = 2;
  localparam int SITE_BITS      = 4 * COORD_BITS;
  localparam int DIR_BITS       = 2;
  localparam int LINK_ADDR_BITS = SITE_BITS + DIR_BITS;
  localparam int LINK_DEPTH     = 1 << LINK_ADDR_BITS;
  localparam int ANGLE_BITS     = 16;
  localparam int BETA_BITS      = 16;
  localparam int REQ_BITS       = 3;
  localparam int REAL_BITS      = 32;
  localparam int IMAG_BITS      = 19;
  localparam int PHASE_BITS     = 19;
  localparam int ACC_BITS       = 27;
  localparam int TOT_BITS       = 12;
  localparam int TERMS          = 6;

  // request codes
  localparam logic [REQ_BITS-1:0] REQ_WRITE  = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_STAPLE = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_ACTION = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_PLAQ   = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_MONO   = 3'd4;

  localparam logic [BETA_BITS-1:0] BETA_RESET = 16'd256;

  // reciprocal of three, exact for values below 2^17
  localparam logic signed [16:0] RECIP3 = 17'sd43691;

  localparam logic signed [PHASE_BITS-1:0] HALF_TURN     = 19'sd32768;
  localparam logic signed [PHASE_BITS-1:0] ONE_HALF_TURN = 19'sd98304;

  // quarter-wave sine, Q1.15
  localparam logic [15:0] QSIN [17] = '{
    16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12539, 16'd15446, 16'd18204,
    16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898, 16'd30273,
    16'd31356, 16'd32137, 16'd32609, 16'd32767
  };

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_RUN, ST_DRAIN, ST_FIN1, ST_FIN2, ST_OUT
  } state_t;

  typedef enum logic [1:0] {SH_NONE, SH_FWD, SH_BWD} shift_t;

  // one plaquette-shaped term: shifted corner, plane, used reads, flux weight
  typedef struct packed {
    shift_t             sh;
    logic [DIR_BITS-1:0] sdir;
    logic [DIR_BITS-1:0] p;
    logic [DIR_BITS-1:0] q;
    logic [3:0]         mask;
    logic signed [1:0]  wt;
  } term_t;

  typedef struct packed {
    logic                      take;
    logic                      acc_clr;
    logic                      wr;
    logic                      wr_zero;
    logic                      rd;
    logic [LINK_ADDR_BITS-1:0] addr;
    logic                      use_rd;
    logic                      sub;
    logic                      first;
    logic                      last;
    logic signed [1:0]         wt;
    logic                      site_end;
    logic                      fin1;
    logic                      fin2;
    logic                      load_out;
    logic [REQ_BITS-1:0]       req;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // one periodic step along a direction
  function automatic logic [SITE_BITS-1:0] site_step(input logic [SITE_BITS-1:0] s,
                                                     input logic [DIR_BITS-1:0] d,
                                                     input logic back);
    logic [SITE_BITS-1:0]  r;
    logic [COORD_BITS-1:0] c;
    int                    lo;
    lo = (3 - int'(d)) * COORD_BITS;
    r = s;
    c = s[lo +: COORD_BITS];
    c = back ? c - 1'b1 : c + 1'b1;
    r[lo +: COORD_BITS] = c;
    return r;
  endfunction

  // term table for each request
  function automatic term_t term_of(input logic [REQ_BITS-1:0] rq,
                                    input logic [DIR_BITS-1:0] mu,
                                    input logic [2:0] t);
    logic [1:0] k;
    logic [DIR_BITS-1:0] nu;
    term_t r;
    k  = t[2:1];
    nu = (k < mu) ? k : 2'(k + 2'd1);
    r  = '{sh: SH_NONE, sdir: 2'd0, p: 2'd0, q: 2'd0, mask: 4'b1111, wt: 2'sd0};
    case (rq)
      REQ_STAPLE: begin
        if (!t[0]) begin
          r.p = nu; r.q = mu; r.mask = 4'b0111;
        end else begin
          r.sh = SH_BWD; r.sdir = nu; r.p = mu; r.q = nu; r.mask = 4'b1011;
        end
      end
      REQ_ACTION: begin
        r.p = mu; r.q = nu;
        if (t[0]) begin
          r.sh = SH_BWD; r.sdir = nu;
        end
      end
      REQ_PLAQ: begin
        case (t)
          3'd0: begin r.p = 2'd0; r.q = 2'd1; end
          3'd1: begin r.p = 2'd0; r.q = 2'd2; end
          3'd2: begin r.p = 2'd0; r.q = 2'd3; end
          3'd3: begin r.p = 2'd1; r.q = 2'd2; end
          3'd4: begin r.p = 2'd1; r.q = 2'd3; end
          default: begin r.p = 2'd2; r.q = 2'd3; end
        endcase
      end
      REQ_MONO: begin
        case (t)
          3'd0: begin r.sh = SH_FWD; r.sdir = 2'd3; r.p = 2'd1; r.q = 2'd2; r.wt = 2'sd1; end
          3'd1: begin r.p = 2'd1; r.q = 2'd2; r.wt = -2'sd1; end
          3'd2: begin r.sh = SH_FWD; r.sdir = 2'd2; r.p = 2'd1; r.q = 2'd3; r.wt = -2'sd1; end
          3'd3: begin r.p = 2'd1; r.q = 2'd3; r.wt = 2'sd1; end
          3'd4: begin r.sh = SH_FWD; r.sdir = 2'd1; r.p = 2'd2; r.q = 2'd3; r.wt = 2'sd1; end
          default: begin r.p = 2'd2; r.q = 2'd3; r.wt = -2'sd1; end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // sine of a phase, table with linear interpolation, Q1.15
  function automatic logic signed [15:0] sin_q15(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]  qd;
    logic [14:0] r;
    logic [4:0]  i;
    logic [15:0] f;
    logic [15:0] v;
    logic [11:0] dlt;
    logic [27:0] pr;
    qd = a[15:14];
    r  = {1'b0, a[13:0]};
    if (qd[0]) r = 15'd16384 - r;
    i  = r[14:10];
    f  = {r[9:0], 6'b0};
    v  = QSIN[i];
    if (i < 5'd16) begin
      dlt = 12'(QSIN[i + 5'd1] - QSIN[i]);
      pr  = dlt * f;
      v   = v + 16'(pr[27:16]);
    end
    return qd[1] ? $signed(16'(-v)) : $signed(v);
  endfunction

  // whole turns removed to bring a phase into the half-turn band
  function automatic logic signed [2:0] turn_count(input logic signed [PHASE_BITS-1:0] p);
    logic signed [2:0] m;
    if (p > ONE_HALF_TURN)       m = 3'sd2;
    else if (p > HALF_TURN)      m = 3'sd1;
    else if (p < -ONE_HALF_TURN) m = -3'sd2;
    else if (p < -HALF_TURN)     m = -3'sd1;
    else                         m = 3'sd0;
    return m;
  endfunction

endpackage

// ----- rtl/core/u1lgm_if.sv -----
interface u1lgm_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [u1lgm_pkg::REQ_BITS-1:0]         req_type;
  logic [u1lgm_pkg::SITE_BITS-1:0]        site;
  logic [u1lgm_pkg::DIR_BITS-1:0]         direction;
  logic [u1lgm_pkg::ANGLE_BITS-1:0]       angle;
  modport source (output valid, req_type, site, direction, angle, input ready);
  modport sink (input valid, req_type, site, direction, angle, output ready);
endinterface

interface u1lgm_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [u1lgm_pkg::REAL_BITS-1:0] value_real;
  logic signed [u1lgm_pkg::IMAG_BITS-1:0] value_imag;
  modport source (output valid, value_real, value_imag, input ready);
  modport sink (input valid, value_real, value_imag, output ready);
endinterface

interface u1lgm_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [u1lgm_pkg::BETA_BITS-1:0]        coupling_beta;
  modport source (output valid, coupling_beta, input ready);
  modport sink (input valid, coupling_beta, output ready);
endinterface

// ----- rtl/core/u1_lattice_gauge_measure_top.sv -----
// compact u(1) gauge field on a periodic 4^4 lattice with local and global
// measurements. req channel takes one word per request (write link, staple,
// local action, plaquette average, monopole density); res returns exactly
// one word per request; cfg writes coupling_beta at any handshake; the user
// must write it only while idle, which the block itself does not enforce.
// all channels move a word when valid and ready are both high.
// the next request is taken in the cycle after the result loads. staple
// and local action read six terms of four links each; plaquette average
// and monopole density sweep all 256 sites, 24 link reads per site.
// the rate is set by the single read port of the link memory: one link
// per cycle. one request is in flight at a time; the next is taken once the
// result sits in the output register, even if the receiver stalls it.
// the output register holds its word until res.ready; a new result waits
// in the datapath until that register frees up.
// reset clears the link memory to zero (cold start) with a sweep over all
// 1024 links, during which req.ready stays low; beta resets to 1.0.
module u1_lattice_gauge_measure_top (
  input  logic        clk,
  input  logic        rst,
  u1lgm_req_if.sink   req,
  u1lgm_res_if.source res,
  u1lgm_cfg_if.sink   cfg
);
  import u1lgm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  u1lgm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  // link memory, arithmetic and result register
  u1lgm_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .angle (req.angle),
    .stat  (stat),
    .cfg   (cfg),
    .res   (res)
  );

endmodule

// ----- rtl/core/u1lgm_ctrl.sv -----
module u1lgm_ctrl (
  input  logic                clk,
  input  logic                rst,
  u1lgm_req_if.sink           req,
  input  u1lgm_pkg::dp_stat_t stat,
  output u1lgm_pkg::dp_cmd_t  cmd
);
  import u1lgm_pkg::*;

  state_t                    state, state_next;
  logic [LINK_ADDR_BITS-1:0] clr_cnt;
  logic [1:0]                k;
  logic [2:0]                t;
  logic [1:0]                dcnt;
  logic [SITE_BITS-1:0]      base;
  logic                      glob;
  logic [REQ_BITS-1:0]       req_q;
  logic [DIR_BITS-1:0]       mu_q;
  term_t                     term;
  logic [SITE_BITS-1:0]      ysite, rsite;
  logic [DIR_BITS-1:0]       rdir;
  logic                      term_end, run_end, accept;

  assign accept = req.valid && req.ready;

  // read address of the current term
  assign term = term_of(req_q, mu_q, t);

  always_comb begin
    unique case (term.sh)
      SH_FWD:  ysite = site_step(base, term.sdir, 1'b0);
      SH_BWD:  ysite = site_step(base, term.sdir, 1'b1);
      default: ysite = base;
    endcase
  end

  always_comb begin
    unique case (k)
      2'd1:    rsite = site_step(ysite, term.p, 1'b0);
      2'd2:    rsite = site_step(ysite, term.q, 1'b0);
      default: rsite = ysite;
    endcase
  end

  assign rdir     = k[0] ? term.q : term.p;
  assign term_end = (k == 2'd3) && (t == 3'(TERMS - 1));
  assign run_end  = term_end && (!glob || (base == '1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_WRITE) state_next = ST_WRITE;
          else if (req.req_type == REQ_STAPLE || req.req_type == REQ_ACTION ||
                   req.req_type == REQ_PLAQ || req.req_type == REQ_MONO)
            state_next = ST_RUN;
          else state_next = ST_FIN1;
        end
      end
      ST_WRITE: state_next = ST_FIN1;
      ST_RUN:   if (run_end) state_next = ST_DRAIN;
      ST_DRAIN: if (dcnt == 2'd2) state_next = ST_FIN1;
      ST_FIN1:  state_next = ST_FIN2;
      ST_FIN2:  state_next = ST_OUT;
      ST_OUT:   if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd       = '0;
    cmd.req   = req_q;
    cmd.addr  = {rsite, rdir};
    req.ready = (state == ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.wr = 1'b1; cmd.wr_zero = 1'b1; cmd.addr = clr_cnt;
      end
      ST_IDLE: begin
        cmd.take = accept; cmd.acc_clr = accept;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1; cmd.addr = {base, mu_q};
      end
      ST_RUN: begin
        cmd.rd       = 1'b1;
        cmd.use_rd   = term.mask[k];
        cmd.sub      = k[1];
        cmd.first    = (k == 2'd0);
        cmd.last     = (k == 2'd3);
        cmd.wt       = term.wt;
        cmd.site_end = term_end;
      end
      ST_FIN1: cmd.fin1 = 1'b1;
      ST_FIN2: cmd.fin2 = 1'b1;
      ST_OUT:  cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      k       <= '0;
      t       <= '0;
      dcnt    <= '0;
      base    <= '0;
      glob    <= 1'b0;
      req_q   <= REQ_WRITE;
      mu_q    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            req_q <= req.req_type;
            mu_q  <= req.direction;
            glob  <= (req.req_type == REQ_PLAQ) || (req.req_type == REQ_MONO);
            base  <= ((req.req_type == REQ_PLAQ) || (req.req_type == REQ_MONO)) ?
                     '0 : req.site;
            k     <= '0;
            t     <= '0;
            dcnt  <= '0;
          end
        end
        ST_RUN: begin
          k <= k + 1'b1;
          if (k == 2'd3) begin
            if (t == 3'(TERMS - 1)) begin
              t    <= '0;
              base <= base + 1'b1;
            end else begin
              t <= t + 1'b1;
            end
          end
        end
        ST_DRAIN: dcnt <= dcnt + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/u1lgm_dp.sv -----
module u1lgm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  u1lgm_pkg::dp_cmd_t               cmd,
  input  logic [u1lgm_pkg::ANGLE_BITS-1:0] angle,
  output u1lgm_pkg::dp_stat_t              stat,
  u1lgm_cfg_if.sink                        cfg,
  u1lgm_res_if.source                      res
);
  import u1lgm_pkg::*;

  logic [ANGLE_BITS-1:0]        links [LINK_DEPTH];
  logic [ANGLE_BITS-1:0]        rdata;
  logic [ANGLE_BITS-1:0]        angle_q;
  logic [BETA_BITS-1:0]         beta;

  // stage a: phase sum
  logic                         a_v, a_use, a_sub, a_first, a_last, a_se;
  logic signed [1:0]            a_wt;
  logic signed [PHASE_BITS-1:0] d_ext, contrib, pacc, pnew;

  // stage b: trig and turn count
  logic                         t_v, t_se;
  logic signed [1:0]            t_wt;
  logic signed [PHASE_BITS-1:0] term_ph;
  logic signed [2:0]            m;
  logic signed [2:0]            mw;
  logic                         b_v, b_se;
  logic signed [15:0]           b_cs, b_sn;
  logic signed [2:0]            b_mw;

  // stage c: accumulators
  logic signed [ACC_BITS-1:0]   re_acc;
  logic signed [IMAG_BITS-1:0]  im_acc;
  logic signed [4:0]            c_acc, c_new;
  logic [4:0]                   c_abs;
  logic [TOT_BITS-1:0]          tot;

  // finish
  logic                         neg_q;
  logic [ACC_BITS-1:0]          absv;
  logic signed [16:0]           mul_a;
  logic signed [19:0]           mul_b;
  logic signed [36:0]           prod;
  logic signed [37:0]           nprod;
  logic [16:0]                  pq;
  logic signed [REAL_BITS-1:0]  real_v, res_real;
  logic signed [IMAG_BITS-1:0]  imag_v, res_imag;

  assign cfg.ready     = 1'b1;
  assign stat.out_free = !res.valid || res.ready;

  // beta register and write word latch
  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= BETA_RESET;
    end else if (cfg.valid) begin
      beta <= cfg.coupling_beta;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) angle_q <= angle;
  end

  // link memory
  always_ff @(posedge clk) begin
    if (cmd.wr) links[cmd.addr] <= cmd.wr_zero ? '0 : angle_q;
    if (cmd.rd) rdata <= links[cmd.addr];
  end

  // read tags follow the memory latency
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= cmd.rd;
    end
    a_use   <= cmd.use_rd;
    a_sub   <= cmd.sub;
    a_first <= cmd.first;
    a_last  <= cmd.last;
    a_wt    <= cmd.wt;
    a_se    <= cmd.site_end;
  end

  // stage a: signed phase sum over the links of one term
  assign d_ext   = PHASE_BITS'(rdata);
  assign contrib = a_use ? (a_sub ? -d_ext : d_ext) : '0;
  assign pnew    = (a_first ? '0 : pacc) + contrib;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= a_v && a_last;
    end
    if (a_v) pacc <= pnew;
    if (a_v && a_last) begin
      term_ph <= pnew;
      t_wt    <= a_wt;
      t_se    <= a_se;
    end
  end

  // stage b: cosine, sine and weighted turn count
  assign m = turn_count(term_ph);

  always_comb begin
    unique case (t_wt)
      2'sd1:   mw = m;
      -2'sd1:  mw = -m;
      default: mw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= t_v;
    end
    b_cs <= sin_q15(ANGLE_BITS'(term_ph[ANGLE_BITS-1:0] + 16'd16384));
    b_sn <= sin_q15(term_ph[ANGLE_BITS-1:0]);
    b_mw <= mw;
    b_se <= t_se;
  end

  // stage c: sums and per-site flux
  assign c_new = c_acc + 5'(b_mw);
  assign c_abs = c_new[4] ? 5'(-c_new) : 5'(c_new);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      re_acc <= '0;
      im_acc <= '0;
      c_acc  <= '0;
      tot    <= '0;
    end else if (b_v) begin
      re_acc <= re_acc + ACC_BITS'(b_cs);
      im_acc <= im_acc + IMAG_BITS'(b_sn);
      if (b_se) begin
        c_acc <= '0;
        tot   <= tot + TOT_BITS'(c_abs);
      end else begin
        c_acc <= c_new;
      end
    end
  end

  // finish: one shared multiplier for beta scaling and the divide by three
  assign absv = re_acc[ACC_BITS-1] ? ACC_BITS'(-re_acc) : ACC_BITS'(re_acc);

  always_comb begin
    if (cmd.req == REQ_ACTION) begin
      mul_a = $signed({1'b0, beta});
      mul_b = 20'($signed(re_acc[IMAG_BITS-1:0]));
    end else begin
      mul_a = RECIP3;
      mul_b = $signed({2'b00, absv[ACC_BITS-1:9]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      prod  <= mul_a * mul_b;
      neg_q <= re_acc[ACC_BITS-1];
    end
  end

  assign nprod = -38'(prod);
  assign pq    = prod[33:17];

  always_comb begin
    real_v = '0;
    imag_v = '0;
    case (cmd.req)
      REQ_STAPLE: begin
        real_v = REAL_BITS'(re_acc);
        imag_v = im_acc;
      end
      REQ_ACTION: real_v = REAL_BITS'(nprod >>> 8);
      REQ_PLAQ:   real_v = neg_q ? -REAL_BITS'(pq) : REAL_BITS'(pq);
      REQ_MONO:   real_v = $signed(REAL_BITS'({tot, 8'b0}));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin2) begin
      res_real <= real_v;
      res_imag <= imag_v;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.value_real <= res_real;
      res.value_imag <= res_imag;
    end
  end

endmodule

// ----- dv/u1_lattice_gauge_measure_top_tb.sv -----
module u1_lattice_gauge_measure_top_tb;
  import u1lgm_pkg::*;

  // codes with no meaning in the block
  localparam logic [REQ_BITS-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_C = 3'd7;
  localparam int NUM_SITES = 1 << SITE_BITS;

  typedef struct {
    logic [REQ_BITS-1:0]   rq;
    logic [SITE_BITS-1:0]  st;
    logic [DIR_BITS-1:0]   dr;
    logic [ANGLE_BITS-1:0] an;
  } lat_req_t;

  typedef struct {
    logic signed [REAL_BITS-1:0] re;
    logic signed [IMAG_BITS-1:0] im;
  } lat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u1lgm_req_if req ();
  u1lgm_res_if res ();
  u1lgm_cfg_if cfg ();

  u1_lattice_gauge_measure_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source),
    .cfg (cfg.sink)
  );

  // clock
  always #6 clk = ~clk;

  // shadow copy of the lattice and beta
  logic [ANGLE_BITS-1:0] link_angle [LINK_DEPTH];
  logic [BETA_BITS-1:0]  beta_now;

  lat_req_t pending_words [$];
  lat_res_t expected_words [$];
  lat_req_t cur_word;
  int       fails = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cnt = 0;
  bit       hold_used = 0;
  bit       hold_go = 0;
  bit       burst = 0;

  // sine of a phase, quarter table with interpolation, Q1.15
  function automatic int sine_of(input logic [ANGLE_BITS-1:0] a);
    int qsin [17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204, 20787, 23170,
                      25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};
    int r, i, f, v;
    r = a[13:0];
    if (a[14]) r = 16384 - r;
    i = r >> 10;
    f = (r << 6) & 16'hFFFF;
    v = qsin[i];
    if (i < 16) v += ((qsin[i+1] - qsin[i]) * f) >>> 16;
    return a[15] ? -v : v;
  endfunction

  function automatic int cosine_of(input logic [ANGLE_BITS-1:0] a);
    return sine_of(ANGLE_BITS'(a + 16'h4000));
  endfunction

  // periodic neighbor along a direction
  function automatic logic [SITE_BITS-1:0] hop(input logic [SITE_BITS-1:0] s,
                                               input int d, input bit back);
    logic [SITE_BITS-1:0] r;
    int lo;
    lo = (3 - d) * COORD_BITS;
    r = s;
    r[lo +: COORD_BITS] = back ? s[lo +: COORD_BITS] - 2'd1 : s[lo +: COORD_BITS] + 2'd1;
    return r;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] ang(input logic [SITE_BITS-1:0] s, input int d);
    return link_angle[{s, 2'(d)}];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] plaq_ang(input logic [SITE_BITS-1:0] s,
                                                     input int mu, input int nu);
    return ang(s, mu) + ang(hop(s, mu, 0), nu) - ang(hop(s, nu, 0), mu) - ang(s, nu);
  endfunction

  // whole turns in an unwrapped plaquette phase
  function automatic int turns_of(input logic [SITE_BITS-1:0] s, input int mu, input int nu);
    int p, m;
    p = int'(ang(s, mu)) + int'(ang(hop(s, mu, 0), nu)) - int'(ang(hop(s, nu, 0), mu))
        - int'(ang(s, nu));
    m = 0;
    while (p > 32768) begin m++; p -= 65536; end
    while (p < -32768) begin m--; p += 65536; end
    return m;
  endfunction

  function automatic int flux_of(input logic [SITE_BITS-1:0] s, input int mu, input int nu,
                                 input int rho);
    return turns_of(hop(s, rho, 0), mu, nu) - turns_of(s, mu, nu);
  endfunction

  // expected word for one accepted request, updating the shadow lattice
  function automatic lat_res_t measure(input lat_req_t w);
    lat_res_t o;
    longint re, im, sum, n;
    int mu, c;
    logic [SITE_BITS-1:0] xm;
    logic [ANGLE_BITS-1:0] a;
    re = 0; im = 0; sum = 0;
    mu = w.dr;
    case (w.rq)
      REQ_WRITE: link_angle[{w.st, w.dr}] = w.an;
      REQ_STAPLE: begin
        for (int nu = 0; nu < 4; nu++) begin
          if (nu == mu) continue;
          xm = hop(w.st, nu, 1);
          a = ang(w.st, nu) + ang(hop(w.st, nu, 0), mu) - ang(hop(w.st, mu, 0), nu);
          re += cosine_of(a); im += sine_of(a);
          a = ang(xm, mu) + ang(hop(xm, mu, 0), nu) - ang(xm, nu);
          re += cosine_of(a); im += sine_of(a);
        end
      end
      REQ_ACTION: begin
        for (int nu = 0; nu < 4; nu++) begin
          if (nu == mu) continue;
          sum += cosine_of(plaq_ang(w.st, mu, nu));
          sum += cosine_of(plaq_ang(hop(w.st, nu, 1), mu, nu));
        end
        n = -(longint'(beta_now) * sum);
        re = n >>> 8;
      end
      REQ_PLAQ: begin
        for (int s = 0; s < NUM_SITES; s++)
          for (int p = 0; p < 3; p++)
            for (int q = p + 1; q < 4; q++)
              sum += cosine_of(plaq_ang(SITE_BITS'(s), p, q));
        re = sum / (6 * NUM_SITES);
      end
      REQ_MONO: begin
        for (int s = 0; s < NUM_SITES; s++) begin
          c = flux_of(SITE_BITS'(s), 1, 2, 3) - flux_of(SITE_BITS'(s), 1, 3, 2)
              + flux_of(SITE_BITS'(s), 2, 3, 1);
          sum += (c < 0) ? -c : c;
        end
        re = (sum * 4 * 65536) / (4 * NUM_SITES);
      end
      default: ;
    endcase
    o.re = re[REAL_BITS-1:0];
    o.im = im[IMAG_BITS-1:0];
    return o;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req.valid && req.ready) expected_words.push_back(measure(cur_word));
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          req.req_type  <= cur_word.rq;
          req.site      <= cur_word.st;
          req.direction <= cur_word.dr;
          req.angle     <= cur_word.an;
          req.valid     <= 1'b1;
          send_gap      <= pick_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    lat_res_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word re=%0d im=%0d", $time, res.value_real,
                   res.value_imag);
          fails++;
        end else begin
          e = expected_words.pop_front();
          if (res.value_real !== e.re) begin
            $display("%0t: value_real expected %0d actual %0d", $time, e.re, res.value_real);
            fails++;
          end
          if (res.value_imag !== e.im) begin
            $display("%0t: value_imag expected %0d actual %0d", $time, e.im, res.value_imag);
            fails++;
          end
        end
      end
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_cnt  <= 400;
        res.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        recv_gap  <= pick_gap();
      end
    end
  end

  task automatic add_word(input logic [REQ_BITS-1:0] rq, input int st, input int dr,
                          input int an);
    lat_req_t w;
    w.rq = rq; w.st = SITE_BITS'(st); w.dr = DIR_BITS'(dr); w.an = ANGLE_BITS'(an);
    pending_words.push_back(w);
  endtask

  // random mix: mostly writes and local queries, few global sweeps
  task automatic add_random(input int count);
    int r, an;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      an = $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) an = 32768 + $urandom_range(0, 2) - 1;
      if (r < 45)      add_word(REQ_WRITE, $urandom_range(0, 255), $urandom_range(0, 3), an);
      else if (r < 70) add_word(REQ_STAPLE, $urandom_range(0, 255), $urandom_range(0, 3), an);
      else if (r < 93) add_word(REQ_ACTION, $urandom_range(0, 255), $urandom_range(0, 3), an);
      else if (r < 95) add_word(REQ_PLAQ, $urandom_range(0, 255), $urandom_range(0, 3), an);
      else if (r < 97) add_word(REQ_MONO, $urandom_range(0, 255), $urandom_range(0, 3), an);
      else             add_word(REQ_BITS'($urandom_range(5, 7)), $urandom_range(0, 255),
                                $urandom_range(0, 3), an);
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() > 0 || req.valid || expected_words.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_beta(input logic [BETA_BITS-1:0] v);
    @(posedge clk);
    cfg.coupling_beta <= v;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    beta_now = v;
    cfg.valid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    logic [BETA_BITS-1:0] betas [5];
    foreach (link_angle[i]) link_angle[i] = '0;
    beta_now = BETA_RESET;
    req.valid = 1'b0; req.req_type = '0; req.site = '0; req.direction = '0; req.angle = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.coupling_beta = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: cold lattice, extremes, half-turn plaquettes, unknown codes
    add_word(REQ_PLAQ, 0, 0, 0);
    add_word(REQ_MONO, 0, 3, 0);
    add_word(REQ_ACTION, 255, 3, 0);
    add_word(REQ_WRITE, 0, 1, 32768);
    add_word(REQ_MONO, 0, 0, 0);
    add_word(REQ_WRITE, 0, 1, 32769);
    add_word(REQ_MONO, 0, 0, 0);
    add_word(REQ_WRITE, 5, 2, 32768);
    add_word(REQ_WRITE, 255, 3, 65535);
    add_word(REQ_WRITE, 255, 0, 16384);
    add_word(REQ_STAPLE, 255, 3, 65535);
    add_word(REQ_STAPLE, 0, 0, 0);
    add_word(REQ_ACTION, 0, 1, 0);
    add_word(REQ_SPARE_A, 255, 3, 65535);
    add_word(REQ_SPARE_B, 170, 2, 43690);
    add_word(REQ_SPARE_C, 85, 1, 21845);
    add_word(REQ_PLAQ, 255, 3, 65535);
    add_word(REQ_MONO, 255, 3, 65535);
    drain();

    // random phases over several beta settings
    betas = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(0, 65535)), 16'd128};
    add_random(190);
    drain();
    foreach (betas[p]) begin
      set_beta(betas[p]);
      burst = (p == 2);
      if (p == 1) hold_go = 1'b1;
      add_random(190);
      drain();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
